FILE: sv/assert_macros.svh
// Assertion macros for the RTL folder.
// Depends on nothing; the user module must declare clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: sv/bpc_pkg.sv
// Shared types and constants of the bigram pair counter.
// Depends on nothing.
package bpc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W       = 16;

  localparam logic [CNT_W-1:0] USED_MAX  = CNT_W'(TABLE_DEPTH);
  localparam logic [VAL_W-1:0] COUNT_MAX = {VAL_W{1'b1}};

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_DUMP = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] first;
    logic [VAL_W-1:0] second;
    logic [VAL_W-1:0] count;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DREAD  = 4'b0100,
    ST_DLOAD  = 4'b1000
  } state_t;

endpackage

FILE: sv/bigram_pair_counter.sv
// Bigram pair counter: top level with pair table, sequencer and output register.
// Depends on bpc_pkg and assert_macros.svh.
//
// Counts overlapping pairs of neighbouring signed 16-bit values. A push item
// (func 0) forms a pair with the previous value and looks it up in a table
// of TABLE_DEPTH entries held in a single-port-read memory: the lookup reads
// one entry per cycle and compares it against the pair with one shared
// comparator, so a push forms no pair for the first value or while the table
// is full, and otherwise scans the filled entries until a hit or their end.
// A hit bumps the count, saturating at 65535; a miss appends the pair with a
// count of one, and filling the last entry sets the full flag, after which
// pushed values are ignored. A dump item (func 1) reads the table out in
// insertion order, one entry at a time, each read and then loaded into the
// output register once the result side is free,
// marks the last item, then clears the table and the pair history. An empty
// table dumps as a single item with entry_valid low. The memory is never
// cleared: only filled entries are used. in_ready is high only while the
// sequencer is idle; one result item is buffered in an output register, so
// a new input item can be taken while the last dumped item waits.
`include "assert_macros.svh"

module bigram_pair_counter
  import bpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic signed [VAL_W-1:0] in_sample_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_first_value,
  output logic signed [VAL_W-1:0] out_second_value,
  output logic        [VAL_W-1:0] out_pair_count,
  output logic                    out_entry_valid,
  output logic                    out_table_was_full,
  output logic                    out_last
);

  // Pair table: written at one address, read at one address, read registered.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rdata_r;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  // Sequencer and history state.
  state_t             state_r, state_nxt;
  logic [VAL_W-1:0]   prev_r, prev_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               full_r, full_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [CNT_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_addr_r, chk_addr_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  entry_t             out_entry_r, out_entry_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic               out_full_r, out_full_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               hit;
  logic               dump_last;
  logic               tbl_empty;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Shared comparator: registered table entry against the pending pair.
  assign hit       = chk_vld_r && (rdata_r.first == prev_r) && (rdata_r.second == val_r);
  assign tbl_empty = (used_r == '0);
  assign dump_last = tbl_empty || ((rd_addr_r + CNT_W'(1)) == used_r);

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    used_nxt      = used_r;
    full_nxt      = full_r;
    val_nxt       = val_r;
    rd_addr_nxt   = rd_addr_r;
    chk_vld_nxt   = chk_vld_r;
    chk_addr_nxt  = chk_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_entry_nxt = out_entry_r;
    out_ev_nxt    = out_ev_r;
    out_full_nxt  = out_full_r;
    out_last_nxt  = out_last_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_addr_r[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = chk_addr_r;
    mem_wdata     = rdata_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_DUMP) begin
            rd_addr_nxt = '0;
            state_nxt   = ST_DREAD;
          end else if (!full_r) begin
            if (!have_prev_r) begin
              // First value: remember it, no pair yet.
              prev_nxt      = in_sample_value;
              have_prev_nxt = 1'b1;
            end else begin
              val_nxt     = in_sample_value;
              rd_addr_nxt = '0;
              chk_vld_nxt = 1'b0;
              state_nxt   = ST_SEARCH;
            end
          end
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          // Bump the matching entry, holding at the maximum.
          mem_we          = 1'b1;
          mem_waddr       = chk_addr_r;
          mem_wdata       = rdata_r;
          if (rdata_r.count != COUNT_MAX) begin
            mem_wdata.count = rdata_r.count + VAL_W'(1);
          end
          prev_nxt        = val_r;
          chk_vld_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
        end else if (!chk_vld_r && (rd_addr_r == used_r)) begin
          // Every filled entry checked: append the pair.
          mem_we           = 1'b1;
          mem_waddr        = used_r[IDX_W-1:0];
          mem_wdata.first  = prev_r;
          mem_wdata.second = val_r;
          mem_wdata.count  = VAL_W'(1);
          used_nxt         = used_r + CNT_W'(1);
          if (used_r == USED_MAX - CNT_W'(1)) begin
            full_nxt = 1'b1;
          end
          prev_nxt  = val_r;
          state_nxt = ST_IDLE;
        end else if (rd_addr_r < used_r) begin
          // Advance the scan: read the next entry, compare it next cycle.
          mem_re       = 1'b1;
          mem_raddr    = rd_addr_r[IDX_W-1:0];
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = rd_addr_r[IDX_W-1:0];
          rd_addr_nxt  = rd_addr_r + CNT_W'(1);
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      ST_DREAD: begin
        mem_re    = 1'b1;
        mem_raddr = rd_addr_r[IDX_W-1:0];
        state_nxt = ST_DLOAD;
      end

      ST_DLOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = tbl_empty ? '0 : rdata_r;
          out_ev_nxt    = !tbl_empty;
          out_full_nxt  = full_r;
          out_last_nxt  = dump_last;
          if (dump_last) begin
            // Drop the table and the pair history.
            prev_nxt      = '0;
            have_prev_nxt = 1'b0;
            used_nxt      = '0;
            full_nxt      = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            rd_addr_nxt = rd_addr_r + CNT_W'(1);
            state_nxt   = ST_DREAD;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      used_r      <= '0;
      full_r      <= 1'b0;
      rd_addr_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      used_r      <= used_nxt;
      full_r      <= full_nxt;
      rd_addr_r   <= rd_addr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    chk_addr_r  <= chk_addr_nxt;
    out_entry_r <= out_entry_nxt;
    out_ev_r    <= out_ev_nxt;
    out_full_r  <= out_full_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_first_value    = out_entry_r.first;
  assign out_second_value   = out_entry_r.second;
  assign out_pair_count     = out_entry_r.count;
  assign out_entry_valid    = out_ev_r;
  assign out_table_was_full = out_full_r;
  assign out_last           = out_last_r;

  `ASSERT_IMP(a_used_bound, 1'b1, used_r <= USED_MAX)
  `ASSERT_IMP(a_full_means_filled, full_r, used_r == USED_MAX)
  `ASSERT_IMP(a_scan_in_range, state_r == ST_SEARCH, rd_addr_r <= used_r)
  `ASSERT_NXT(a_dump_clears, (state_r == ST_DLOAD) && out_free && dump_last, (used_r == '0) && !full_r && !have_prev_r)

endmodule
